// File: src/idt_pkg.sv
// Shared types and constants for the card ID table.
package idt_pkg;

   localparam int CAP_DEFAULT = 64;
   localparam int ID_W        = 32;
   localparam int SLOT_W      = 7;

   typedef enum logic [1:0] {
      ACT_LOOKUP   = 2'd0,
      ACT_ADD      = 2'd1,
      ACT_ID_DEL   = 2'd2,
      ACT_SLOT_DEL = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD_SLOT  = 3'd4,
      ST_INVALID   = 3'd5
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [ID_W-1:0]     card_id;
      logic [SLOT_W-1:0]   slot_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_found;
      logic [SLOT_W-1:0]   entry_count;
   } rsp_type;

endpackage

// File: src/idt_mem.sv
// ID store: one write port, one read port, registered read data.
module idt_mem
   import idt_pkg::*;
#(
   parameter int DEPTH  = CAP_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ID_W-1:0]   wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ID_W-1:0]   rd_data
);

   logic [ID_W-1:0] mem_ff [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/idt_ctrl.sv
// Sequencer: search walk, append and compacting shift over the ID store.
module idt_ctrl
   import idt_pkg::*;
#(
   parameter int CAPACITY = CAP_DEFAULT,
   parameter int ADDR_W   = 6,
   parameter int CNT_W    = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [ID_W-1:0]   wr_data,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [ID_W-1:0]   rd_data
);

   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SRCH  = 3'b010,
      S_SHIFT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [ID_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;     // next entry to read
   logic              pend_ff, pend_in;   // read data arriving this cycle
   logic [CNT_W-1:0]  pidx_ff, pidx_in;   // compare index or shift target
   logic [CNT_W-1:0]  slot_ff, slot_in;   // 1-based slot being removed
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              issue;
   logic              hit;
   logic              key_bad;
   logic              slot_bad;

   assign issue    = idx_ff < count_ff;
   assign hit      = pend_ff && (rd_data == key_ff);
   assign key_bad  = (req_data.action != ACT_SLOT_DEL) && (req_data.card_id[31:24] == 8'd0);
   assign slot_bad = (req_data.slot_index == '0) ||
                     (CMP_W'(req_data.slot_index) > CMP_W'(count_ff));

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff[ADDR_W-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = req_data.action;
               key_in  = req_data.card_id;
               idx_in  = '0;
               pend_in = 1'b0;
               if (key_bad) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = ST_INVALID;
                  rsp_in.slot_found  = '0;
                  rsp_in.entry_count = SLOT_W'(count_ff);
               end else if (req_data.action == ACT_SLOT_DEL) begin
                  if (slot_bad) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.status      = ST_BAD_SLOT;
                     rsp_in.slot_found  = '0;
                     rsp_in.entry_count = SLOT_W'(count_ff);
                  end else begin
                     slot_in  = CNT_W'(req_data.slot_index);
                     idx_in   = CNT_W'(req_data.slot_index);
                     state_in = S_SHIFT;
                  end
               end else begin
                  state_in = S_SRCH;
               end
            end
         end

         // pipelined walk: issue one read and compare the previous one per cycle
         S_SRCH: begin
            if (hit) begin
               pend_in = 1'b0;
               if (act_ff == ACT_ID_DEL) begin
                  slot_in  = pidx_ff + 1'b1;
                  idx_in   = pidx_ff + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = (act_ff == ACT_ADD) ? ST_DUPLICATE : ST_OK;
                  rsp_in.slot_found  = SLOT_W'(pidx_ff + 1'b1);
                  rsp_in.entry_count = SLOT_W'(count_ff);
                  state_in           = S_IDLE;
               end
            end else if (!issue && !pend_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (act_ff != ACT_ADD) begin
                  rsp_in.status      = ST_NOT_FOUND;
                  rsp_in.slot_found  = '0;
                  rsp_in.entry_count = SLOT_W'(count_ff);
               end else if (CMP_W'(count_ff) >= CMP_W'(CAPACITY)) begin
                  rsp_in.status      = ST_FULL;
                  rsp_in.slot_found  = '0;
                  rsp_in.entry_count = SLOT_W'(count_ff);
               end else begin
                  // append at the end of the table
                  wr_en              = 1'b1;
                  wr_addr            = count_ff[ADDR_W-1:0];
                  wr_data            = key_ff;
                  count_in           = count_ff + 1'b1;
                  rsp_in.status      = ST_OK;
                  rsp_in.slot_found  = SLOT_W'(count_in);
                  rsp_in.entry_count = SLOT_W'(count_in);
               end
            end else begin
               pend_in = issue;
               if (issue) begin
                  rd_en   = 1'b1;
                  idx_in  = idx_ff + 1'b1;
                  pidx_in = idx_ff;
               end
            end
         end

         // compacting shift: read entry i+1, write it back at i in the next cycle
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            pend_in = issue;
            if (issue) begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
               pidx_in = idx_ff - 1'b1;
            end else if (!pend_ff) begin
               count_in           = count_ff - 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.slot_found  = SLOT_W'(slot_ff);
               rsp_in.entry_count = SLOT_W'(count_in);
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      pidx_ff <= pidx_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/id_table_insert_delete_lookup.sv
// Ordered card ID table with lookup, add and compacting delete.
//
// Request: drive req_data and raise start; a beat is taken on an edge where
// start is high and busy is low. Actions are lookup, add, delete by ID and
// delete by slot. Each beat gives exactly one response: rsp_valid is high
// for one cycle with rsp_data (status, 1-based slot, count after action).
// The receiver cannot stall; the strobe is not held.
//
// Response time is set by the single read port of the ID store, walked one
// entry per cycle with reads pipelined against compares or write-backs.
// busy is high while an item is in progress; one item at a time.
// Reset empties the table at once (count to zero); no clearing pass.
module id_table_insert_delete_lookup
   import idt_pkg::*;
#(
   parameter int CAPACITY = CAP_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ID_W-1:0]   wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ID_W-1:0]   rd_data;

   idt_ctrl #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   idt_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an accepted beat either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted beat neither answered nor in progress");

   // count never exceeds table capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= SLOT_W'(CAPACITY)))
      else $error("entry count above capacity");

   // failure statuses carry no slot
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK && rsp_data.status != ST_DUPLICATE)
      |-> (rsp_data.slot_found == '0))
      else $error("failure response carries a slot");

   // an OK response that names the last slot never reports an empty table
   a_add_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK && busy == 1'b0 &&
       rsp_data.slot_found == rsp_data.entry_count) |-> (rsp_data.entry_count != '0))
      else $error("slot reported in an empty table");

endmodule

// File: bench/id_table_insert_delete_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for the card ID table: directed, fill and random beats checked against a mirror.
module id_table_insert_delete_lookup_tb;
   import idt_pkg::*;

   localparam int CAP          = CAP_DEFAULT;
   localparam int MAX_LATENCY  = 2 * CAP + 8;
   localparam int IDLE_LIMIT   = 1500;
   localparam int RANDOM_BEATS = 1650;
   localparam int POOL_SIZE    = 96;
   localparam int PHASE_LEN    = 300;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // mirror of the table contents and the responses still owed
   logic [ID_W-1:0] id_mirror [CAP];
   int              count_mirror;
   int              peak_count;
   rsp_type         owed_rsp [$];
   logic [ID_W-1:0] id_pool [POOL_SIZE];

   int  mismatches;
   int  beats_sent;
   int  rsp_seen;
   int  idle_cycles;
   int  status_hits [6];
   bit  no_gaps;

   id_table_insert_delete_lookup #(
      .CAPACITY (CAP)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // first slot (1-based) holding key, 0 on a miss
   function automatic int find_card(logic [ID_W-1:0] key);
      for (int i = 0; i < count_mirror; i++) begin
         if (id_mirror[i] == key) return i + 1;
      end
      return 0;
   endfunction

   // remove slot s and close the gap; vacated tail entry is zeroed
   function automatic void remove_card(int s);
      for (int i = s - 1; i + 1 < count_mirror; i++) begin
         id_mirror[i] = id_mirror[i + 1];
      end
      id_mirror[count_mirror - 1] = '0;
      count_mirror--;
   endfunction

   // apply one request to the mirror and return the response it owes
   function automatic rsp_type apply_card_action(req_type r);
      rsp_type o;
      int      s;
      o.status = ST_OK;
      s = 0;
      if (r.action != ACT_SLOT_DEL && r.card_id[ID_W-1 -: 8] == 8'd0) begin
         o.status = ST_INVALID;
      end else begin
         case (r.action)
            ACT_LOOKUP: begin
               s = find_card(r.card_id);
               if (s == 0) o.status = ST_NOT_FOUND;
            end
            ACT_ADD: begin
               s = find_card(r.card_id);
               if (s != 0) begin
                  o.status = ST_DUPLICATE;
               end else if (count_mirror >= CAP) begin
                  o.status = ST_FULL;
               end else begin
                  id_mirror[count_mirror] = r.card_id;
                  count_mirror++;
                  s = count_mirror;
               end
            end
            ACT_ID_DEL: begin
               s = find_card(r.card_id);
               if (s != 0) remove_card(s);
               else o.status = ST_NOT_FOUND;
            end
            ACT_SLOT_DEL: begin
               if (r.slot_index == 0 || int'(r.slot_index) > count_mirror) begin
                  o.status = ST_BAD_SLOT;
               end else begin
                  s = int'(r.slot_index);
                  remove_card(s);
               end
            end
         endcase
      end
      if (count_mirror > peak_count) peak_count = count_mirror;
      status_hits[o.status]++;
      o.slot_found  = SLOT_W'(s);
      o.entry_count = SLOT_W'(count_mirror);
      return o;
   endfunction

   // idle length before a beat: mostly none or short, sometimes long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [ID_W-1:0] valid_card();
      return {8'($urandom_range(1, 255)), 24'($urandom)};
   endfunction

   // drive one request, hold it until taken, then log what it owes
   task automatic send_beat(action_type act, logic [ID_W-1:0] id, logic [SLOT_W-1:0] sidx);
      req_type r;
      int      gap;
      r.action     = act;
      r.card_id    = id;
      r.slot_index = sidx;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      owed_rsp.push_back(apply_card_action(r));
      beats_sent++;
   endtask

   // stop sending and let every owed response arrive
   task automatic hold_until_drained();
      start <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
   endtask

   // response check: one strobe, one beat, compared against the oldest owed entry
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (owed_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none owed: status %0d slot %0d count %0d",
                        $realtime, rsp_data.status, rsp_data.slot_found,
                        rsp_data.entry_count);
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.slot_found !== want.slot_found ||
                rsp_data.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch: expected status %0d slot %0d count %0d,",
                            " got status %0d slot %0d count %0d"},
                           $realtime, want.status, want.slot_found, want.entry_count,
                           rsp_data.status, rsp_data.slot_found, rsp_data.entry_count);
            end
         end
      end
   end

   // watchdog: too long without a request or response beat ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // extremes of the fields and every special case but a full table, on a small table
   task automatic test_directed();
      send_beat(ACT_LOOKUP,   32'h12345678, 7'd0);    // miss on empty table
      send_beat(ACT_LOOKUP,   32'h00FFFFFF, 7'd0);    // zero first byte
      send_beat(ACT_ADD,      32'h00000000, 7'd0);
      send_beat(ACT_ID_DEL,   32'h00ABCDEF, 7'd0);
      send_beat(ACT_SLOT_DEL, 32'hFFFFFFFF, 7'd1);    // slot past empty table
      send_beat(ACT_ADD,      32'hFFFFFFFF, 7'd127);
      send_beat(ACT_ADD,      32'h01000000, 7'd0);
      send_beat(ACT_ADD,      32'h80000001, 7'd0);
      send_beat(ACT_ADD,      32'hFFFFFFFF, 7'd0);    // duplicate
      send_beat(ACT_ADD,      32'hFFFFFFFE, 7'd0);    // last byte differs only
      send_beat(ACT_LOOKUP,   32'hFFFFFFFE, 7'd0);
      send_beat(ACT_LOOKUP,   32'h7FFFFFFF, 7'd0);    // first byte differs only
      send_beat(ACT_ID_DEL,   32'h01000000, 7'd0);    // middle delete, shift
      send_beat(ACT_LOOKUP,   32'h80000001, 7'd0);
      send_beat(ACT_SLOT_DEL, 32'h12345678, 7'd0);    // slot zero
      send_beat(ACT_SLOT_DEL, 32'h12345678, 7'd127);
      send_beat(ACT_SLOT_DEL, 32'h12345678, 7'd4);    // one above count
      send_beat(ACT_SLOT_DEL, 32'h00000000, 7'd3);    // id ignored for slot delete
      send_beat(ACT_ID_DEL,   32'h12345678, 7'd0);    // delete miss
      send_beat(ACT_SLOT_DEL, 32'hFFFFFFFF, 7'd1);
      send_beat(ACT_LOOKUP,   32'h80000001, 7'd0);
      send_beat(ACT_SLOT_DEL, 32'h00000000, 7'd1);    // empties the table
      hold_until_drained();
   endtask

   // fill to capacity, hit the full case and the end slots, then drain
   task automatic test_full_table();
      logic [ID_W-1:0] id;
      no_gaps = 1'b1;
      while (count_mirror < CAP) begin
         id = valid_card();
         send_beat(ACT_ADD, id, 7'($urandom));
      end
      no_gaps = 1'b0;
      do id = valid_card(); while (find_card(id) != 0);
      send_beat(ACT_ADD, id, 7'd0);                     // full
      send_beat(ACT_ADD, id_mirror[CAP - 1], 7'd0);     // duplicate of last slot
      send_beat(ACT_LOOKUP, id_mirror[CAP - 1], 7'd0);
      send_beat(ACT_ID_DEL, id_mirror[CAP - 1], 7'd0);
      send_beat(ACT_SLOT_DEL, id, 7'(CAP));             // one above count
      send_beat(ACT_ADD, id, 7'd0);
      send_beat(ACT_SLOT_DEL, id, 7'(CAP));
      send_beat(ACT_SLOT_DEL, id, 7'(CAP + 1));
      while (count_mirror > 0)
         send_beat(ACT_SLOT_DEL, $urandom, 7'($urandom_range(1, count_mirror)));
      hold_until_drained();
   endtask

   // random mix over a small ID pool, in phases that grow or shrink the table
   task automatic test_random();
      bit              grow;
      int              roll;
      action_type      act;
      logic [ID_W-1:0] id;
      logic [SLOT_W-1:0] sidx;
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = valid_card();
      grow = 1'b1;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % PHASE_LEN == 0) begin
            grow    = (n / PHASE_LEN) % 2 == 0;
            no_gaps = $urandom_range(0, 3) == 0;
         end
         if (n % 450 == 449) hold_until_drained();

         roll = $urandom_range(0, 99);
         if (roll < 25) act = ACT_LOOKUP;
         else if (roll < (grow ? 70 : 45)) act = ACT_ADD;
         else if (roll < (grow ? 85 : 75)) act = ACT_ID_DEL;
         else act = ACT_SLOT_DEL;

         roll = $urandom_range(0, 99);
         if (roll < 70) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (roll < 80 && count_mirror > 0)
            id = id_mirror[$urandom_range(0, count_mirror - 1)];
         else if (roll < 92) id = $urandom;
         else id = {8'd0, 24'($urandom)};

         roll = $urandom_range(0, 99);
         if (roll < 75 && count_mirror > 0) sidx = 7'($urandom_range(1, count_mirror));
         else if (roll < 85) sidx = 7'd0;
         else if (roll < 95) sidx = 7'($urandom_range(count_mirror + 1, CAP + 1));
         else sidx = 7'($urandom_range(0, 127));

         send_beat(act, id, sidx);
      end
      hold_until_drained();
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      count_mirror = 0;
      peak_count   = 0;
      mismatches   = 0;
      beats_sent   = 0;
      rsp_seen     = 0;
      idle_cycles  = 0;
      no_gaps      = 1'b0;
      foreach (status_hits[k]) status_hits[k] = 0;
      foreach (id_mirror[k]) id_mirror[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_table();
      test_random();

      // late or extra responses show up as unowed beats
      repeat (MAX_LATENCY) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, table peaked at %0d of %0d",
               beats_sent, rsp_seen, peak_count, CAP);
      $display("Status mix ok/miss/dup/full/bad slot/invalid: %0d/%0d/%0d/%0d/%0d/%0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5]);
      if (mismatches == 0 && owed_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatches, owed_rsp.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/idt_pkg.sv
src/idt_mem.sv
src/idt_ctrl.sv
src/id_table_insert_delete_lookup.sv
bench/id_table_insert_delete_lookup_tb.sv
